/* sv/tor_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tor_pkg
// Shared types and constants for the Telnet option refuser and line splitter.
// ----------------------------------------------------------------------------
package tor_pkg;

    localparam logic [7:0] CODE_IAC   = 8'd255;
    localparam logic [7:0] CODE_WILL  = 8'd251;
    localparam logic [7:0] CODE_WONT  = 8'd252;
    localparam logic [7:0] CODE_DO    = 8'd253;
    localparam logic [7:0] CODE_DONT  = 8'd254;
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] IDLE_RESET = 8'd30;

    // Largest capacity that still fits the 7-bit position field
    localparam int POS_MAX = 127;

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_WILL   = 3'd2,
        PS_WONT   = 3'd3,
        PS_DO     = 3'd4,
        PS_DONT   = 3'd5
    } parse_state_t;

    typedef enum logic [2:0] {
        KIND_CHAR    = 3'd0,
        KIND_RESTART = 3'd1,
        KIND_EOL     = 3'd2,
        KIND_REPLY   = 3'd3,
        KIND_DROP    = 3'd4,
        KIND_CLOSE   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic [6:0] position;
        logic       last;
    } result_t;

endpackage

/* sv/telnet_option_refuser_line_splitter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_refuser_line_splitter_top
// Telnet receive filter: strips IAC sequences, refuses all options, splits
// lines and closes idle connections.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per received byte
//   (func = 0, rx_byte) or per poll tick (func = 1). Output channel
//   (out_valid / out_stall) carries result beats: kind, byte_value, position,
//   and last, which marks the final beat caused by one input beat.
//   An input beat lands in an input register, is decoded from it, and
//   its zero to three results are pushed into a four-entry result queue.
//   Throughput is one input beat per cycle while each beat yields at most one
//   result and the receiver does not stall; a negotiation reply is three beats
//   and the output port drains one beat per cycle while out_stall is low.
//   The decode stage fires only when the queue holds at most one entry, so
//   in_stall is a function of registers only.
//   When the receiver stalls, the queue fills and in_stall rises; nothing is
//   dropped. cfg_wr_en/cfg_wr_data write idle_limit; write only while idle.
//   Reset clears the parser, line length, idle count and queue, and sets
//   idle_limit to 30. An idle close returns the parser to its reset state
//   but keeps idle_limit.
// ----------------------------------------------------------------------------
module telnet_option_refuser_line_splitter_top
    import tor_pkg::*;
#(
    parameter int LINE_CAPACITY = 80
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] byte_value,
    output logic [6:0] position,
    output logic       last
);

    localparam int         CAP_INT = (LINE_CAPACITY > POS_MAX) ? POS_MAX : LINE_CAPACITY;
    localparam logic [6:0] CAP     = 7'(CAP_INT);
    localparam int         QDEPTH  = 4;

    // Input register
    logic       stage_valid_reg;
    logic       stage_func_reg;
    logic [7:0] stage_byte_reg;

    // Block state
    parse_state_t parse_reg, parse_next;
    logic [6:0]   line_len_reg, line_len_next;
    logic [7:0]   idle_reg, idle_next;
    logic [7:0]   idle_limit_reg;

    // Result queue
    result_t    queue_mem [QDEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    logic       fire;
    logic       pop;
    logic       accept;
    logic       closing;
    logic [7:0] idle_inc;
    result_t    res [3];
    logic [1:0] res_n;

    assign fire   = stage_valid_reg && (count_reg <= 3'd1);
    assign in_stall = stage_valid_reg && !fire;
    assign accept = in_valid && !in_stall;
    assign pop    = out_valid && !out_stall;

    assign idle_inc = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;
    assign closing  = stage_func_reg && (idle_inc > idle_limit_reg);

    // Next parser state
    always_comb
    begin
        parse_next = PS_NORMAL;
        if (stage_func_reg) begin
            parse_next = closing ? PS_NORMAL : parse_reg;
        end else begin
            unique case (parse_reg)
                PS_IAC:
                begin
                    case (stage_byte_reg)
                        CODE_WILL: parse_next = PS_WILL;
                        CODE_WONT: parse_next = PS_WONT;
                        CODE_DO:   parse_next = PS_DO;
                        CODE_DONT: parse_next = PS_DONT;
                        default:   parse_next = PS_NORMAL;
                    endcase
                end
                PS_WILL, PS_WONT, PS_DO, PS_DONT:
                begin
                    parse_next = PS_NORMAL;
                end
                default:
                begin
                    parse_next = (stage_byte_reg == CODE_IAC) ? PS_IAC : PS_NORMAL;
                end
            endcase
        end
    end

    // Results, line length and idle count
    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            res[k] = '{kind: KIND_REPLY, byte_value: 8'd0, position: 7'd0, last: 1'b0};
        end
        res_n         = 2'd0;
        line_len_next = line_len_reg;
        idle_next     = 8'd0;

        if (stage_func_reg) begin
            idle_next = idle_inc;
            if (closing) begin
                res[0]        = '{kind: KIND_CLOSE, byte_value: 8'd0, position: 7'd0,
                                  last: 1'b1};
                res_n         = 2'd1;
                line_len_next = 7'd0;
                idle_next     = 8'd0;
            end
        end else begin
            unique case (parse_reg)
                PS_IAC:
                begin
                    if (stage_byte_reg == CODE_IAC) begin
                        res[0]        = '{kind: KIND_RESTART, byte_value: CODE_IAC,
                                          position: 7'd0, last: 1'b1};
                        res_n         = 2'd1;
                        line_len_next = 7'd1;
                    end
                end
                PS_WILL, PS_WONT, PS_DO, PS_DONT:
                begin
                    // Refuse: WILL/WONT -> DONT, DO/DONT -> WONT
                    res[0].byte_value = CODE_IAC;
                    res[1].byte_value = ((parse_reg == PS_WILL) || (parse_reg == PS_WONT))
                                        ? CODE_DONT : CODE_WONT;
                    res[2].byte_value = stage_byte_reg;
                    res[2].last       = 1'b1;
                    res_n             = 2'd3;
                end
                default:
                begin
                    if (stage_byte_reg == CODE_IAC || stage_byte_reg == CODE_CR) begin
                        res_n = 2'd0;
                    end else if (stage_byte_reg == CODE_LF) begin
                        res[0]        = '{kind: KIND_EOL, byte_value: CODE_LF,
                                          position: line_len_reg, last: 1'b1};
                        res_n         = 2'd1;
                        line_len_next = 7'd0;
                    end else if (line_len_reg >= CAP) begin
                        res[0] = '{kind: KIND_DROP, byte_value: stage_byte_reg,
                                   position: CAP, last: 1'b1};
                        res_n  = 2'd1;
                    end else begin
                        res[0]        = '{kind: KIND_CHAR, byte_value: stage_byte_reg,
                                          position: line_len_reg, last: 1'b1};
                        res_n         = 2'd1;
                        line_len_next = line_len_reg + 7'd1;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            parse_reg       <= PS_NORMAL;
            line_len_reg    <= 7'd0;
            idle_reg        <= 8'd0;
            idle_limit_reg  <= IDLE_RESET;
            wr_ptr_reg      <= 2'd0;
            rd_ptr_reg      <= 2'd0;
            count_reg       <= 3'd0;
        end else begin
            if (cfg_wr_en) begin
                idle_limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                stage_valid_reg <= 1'b1;
            end else if (fire) begin
                stage_valid_reg <= 1'b0;
            end
            if (fire) begin
                parse_reg    <= parse_next;
                line_len_reg <= line_len_next;
                idle_reg     <= idle_next;
                wr_ptr_reg   <= wr_ptr_reg + res_n;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (fire ? {1'b0, res_n} : 3'd0) - {2'b0, pop};
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept) begin
            stage_func_reg <= func;
            stage_byte_reg <= rx_byte;
        end
        if (fire) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < res_n) begin
                    queue_mem[wr_ptr_reg + 2'(k)] <= res[k];
                end
            end
        end
    end

    assign out_valid  = (count_reg != 3'd0);
    assign kind       = queue_mem[rd_ptr_reg].kind;
    assign byte_value = queue_mem[rd_ptr_reg].byte_value;
    assign position   = queue_mem[rd_ptr_reg].position;
    assign last       = queue_mem[rd_ptr_reg].last;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QDEPTH))
        else $error("result queue overflow");

    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_len_reg <= CAP)
        else $error("line length beyond capacity");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && closing |=> (line_len_reg == 7'd0) && (idle_reg == 8'd0)
                            && (parse_reg == PS_NORMAL))
        else $error("idle close did not clear state");

    a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !stage_func_reg |=> idle_reg == 8'd0)
        else $error("received byte did not clear idle count");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> !in_stall)
        else $error("stall with empty input register");
`endif

endmodule
